>>> src/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expects signals named clk and rst_n
// in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// The condition must never be true.
`define ASSERT_NEVER(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

>>> src/hbp_pkg.sv
package hbp_pkg;

    localparam int DEF_BINS       = 16;
    localparam int DEF_COUNT_BITS = 20;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam int CMD_W   = 3;
    localparam int CHAN_W  = 16;
    localparam int DIFF_W  = CHAN_W + 1;
    localparam int ENTRY_W = 12;
    localparam int LIKE_W  = 16;
    localparam int RATIO_W = 16;
    localparam int NORM_W  = 24;
    localparam int FRAC_W  = 8 + 8;

    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 24;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int BIN_PROD_W = DIFF_W + CHAN_W;
    localparam int CLIP_W     = 41;
    localparam int SHIFT_PRIM = 8;
    localparam int RES_SHIFT  = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLASSIFY = 3'd0,
        CMD_INSERT   = 3'd1,
        CMD_WRITE    = 3'd2,
        CMD_FLUSH    = 3'd3,
        CMD_MERGE    = 3'd4
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_CH1 = 3'd0,
        CFG_START_CH2 = 3'd1,
        CFG_START_CH3 = 3'd2,
        CFG_SCALE_CH1 = 3'd3,
        CFG_SCALE_CH2 = 3'd4,
        CFG_SCALE_CH3 = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_8,
        SH_32
    } mac_shift_t;

    typedef struct packed {
        logic       issue;
        logic       clear;
        mac_shift_t shift;
    } mac_ctl_t;

    typedef struct packed {
        logic rd_en;
        logic prim_we;
        logic cnt_we;
    } tbl_ctl_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_BIN_A,
        S_BIN_B,
        S_BIN_C,
        S_EVAL_B,
        S_EVAL_C,
        S_LOOKUP,
        S_UPDATE,
        S_WRITE,
        S_FLUSH,
        S_M_READ,
        S_M_MUL_C,
        S_M_WAIT_C,
        S_M_CLIP,
        S_M_MUL_LO,
        S_M_MUL_HI,
        S_M_MUL_P,
        S_M_WAIT_S,
        S_M_STORE,
        S_DONE
    } state_t;

endpackage

>>> src/hbp_mac.sv
module hbp_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hbp_pkg::mac_ctl_t             ctl,
    input  logic [hbp_pkg::MUL_A_W-1:0]   op_a,
    input  logic [hbp_pkg::MUL_B_W-1:0]   op_b,
    output logic [hbp_pkg::ACC_W-1:0]     acc
);
    import hbp_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    mac_ctl_t          ctl_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  addend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
        if (ctl_reg.issue)
        begin
            acc_reg <= (ctl_reg.clear ? '0 : acc_reg) + addend;
        end
    end

    always_comb
    begin
        case (ctl_reg.shift)
            SH_0:    addend = ACC_W'(prod_reg);
            SH_8:    addend = ACC_W'(prod_reg) << SHIFT_PRIM;
            SH_32:   addend = ACC_W'(prod_reg) << MUL_A_W;
            default: addend = ACC_W'(prod_reg);
        endcase
    end

    assign acc = acc_reg;

endmodule

>>> src/hbp_tables.sv
module hbp_tables #(
    parameter  int DEPTH  = hbp_pkg::DEF_BINS * hbp_pkg::DEF_BINS * hbp_pkg::DEF_BINS,
    parameter  int CNT_W  = hbp_pkg::DEF_COUNT_BITS,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  hbp_pkg::tbl_ctl_t            ctl,
    input  logic [ADDR_W-1:0]            addr,
    input  logic [hbp_pkg::LIKE_W-1:0]   prim_wdata,
    input  logic [CNT_W-1:0]             cnt_wdata,
    output logic [hbp_pkg::LIKE_W-1:0]   prim_rdata,
    output logic [CNT_W-1:0]             cnt_rdata
);
    import hbp_pkg::*;

    logic [LIKE_W-1:0] prim_mem [DEPTH];
    logic [CNT_W-1:0]  cnt_mem  [DEPTH];
    logic [LIKE_W-1:0] prim_rdata_reg;
    logic [CNT_W-1:0]  cnt_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.prim_we)
        begin
            prim_mem[addr] <= prim_wdata;
        end
        if (ctl.rd_en)
        begin
            prim_rdata_reg <= prim_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cnt_we)
        begin
            cnt_mem[addr] <= cnt_wdata;
        end
        if (ctl.rd_en)
        begin
            cnt_rdata_reg <= cnt_mem[addr];
        end
    end

    assign prim_rdata = prim_rdata_reg;
    assign cnt_rdata  = cnt_rdata_reg;

endmodule

>>> src/color_histogram_backprojection.sv
// Color histogram backprojection over a BINS_A x BINS_B x BINS_C grid, holding a table of
// likelihoods and a table of saturating counts in single-port memories. One multiplier with an
// accumulator does all multiplication under a sequencer, and the block takes one beat at a time.
// After reset the count table is cleared in a pass over all BINS_A*BINS_B*BINS_C entries,
// during which in_stall stays high; configuration writes are taken at any time. A classify or
// insert beat sends three binning products through the multiplier and its two-stage pipeline,
// then does one table read and, for an insert, one count write-back; a write beat does one table
// write, a flush beat clears every count entry, and a merge beat works through every table entry,
// each needing four products and a read and a write on the single table port.
`include "assert_macros.svh"

module color_histogram_backprojection #(
    parameter int BINS_A     = hbp_pkg::DEF_BINS,
    parameter int BINS_B     = hbp_pkg::DEF_BINS,
    parameter int BINS_C     = hbp_pkg::DEF_BINS,
    parameter int COUNT_BITS = hbp_pkg::DEF_COUNT_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hbp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hbp_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [hbp_pkg::CMD_W-1:0]           cmd,
    input  logic signed [hbp_pkg::CHAN_W-1:0]   chan_a,
    input  logic signed [hbp_pkg::CHAN_W-1:0]   chan_b,
    input  logic signed [hbp_pkg::CHAN_W-1:0]   chan_c,
    input  logic [hbp_pkg::ENTRY_W-1:0]         entry_index,
    input  logic [hbp_pkg::LIKE_W-1:0]          entry_value,
    input  logic [hbp_pkg::RATIO_W-1:0]         blend_ratio,
    input  logic [hbp_pkg::NORM_W-1:0]          count_norm,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [hbp_pkg::LIKE_W-1:0]          likelihood,
    output logic                                in_range
);
    import hbp_pkg::*;

    localparam int TABLE_SIZE = BINS_A * BINS_B * BINS_C;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam logic [ADDR_W-1:0]     LAST_ADDR  = ADDR_W'(TABLE_SIZE - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [ACC_W-1:0]      MERGE_CLIP = ACC_W'(1) << (CLIP_W - 1);
    localparam logic [ACC_W:0]        ROUND_HALF = (ACC_W + 1)'(1) << (RES_SHIFT - 1);

    state_t state_reg;
    state_t state_next;
    logic [ADDR_W-1:0] sweep_reg;
    logic [ADDR_W-1:0] sweep_next;

    logic signed [CHAN_W-1:0] start_ch1_reg;
    logic signed [CHAN_W-1:0] start_ch2_reg;
    logic signed [CHAN_W-1:0] start_ch3_reg;
    logic [CHAN_W-1:0]        scale_ch1_reg;
    logic [CHAN_W-1:0]        scale_ch2_reg;
    logic [CHAN_W-1:0]        scale_ch3_reg;

    logic [CMD_W-1:0]         cmd_reg;
    logic signed [CHAN_W-1:0] chan_a_reg;
    logic signed [CHAN_W-1:0] chan_b_reg;
    logic signed [CHAN_W-1:0] chan_c_reg;
    logic [ENTRY_W-1:0]       entry_index_reg;
    logic [LIKE_W-1:0]        entry_value_reg;
    logic [RATIO_W-1:0]       blend_ratio_reg;
    logic [NORM_W-1:0]        count_norm_reg;

    logic                     ok_reg;
    logic [LIKE_W-1:0]        like_reg;
    logic [ADDR_W-1:0]        idx_reg;
    logic [CLIP_W-1:0]        a_reg;

    logic                     out_valid_reg;
    logic [LIKE_W-1:0]        likelihood_reg;
    logic                     in_range_reg;

    logic signed [DIFF_W-1:0] diff_a;
    logic signed [DIFF_W-1:0] diff_b;
    logic signed [DIFF_W-1:0] diff_c;
    logic [DIFF_W-1:0]        mag_a;
    logic [DIFF_W-1:0]        mag_b;
    logic [DIFF_W-1:0]        mag_c;

    logic                     eval_neg;
    logic [DIFF_W-1:0]        eval_bins;
    logic [DIFF_W-1:0]        eval_q;
    logic                     eval_ok;
    logic [DIFF_W-1:0]        eval_bin;

    logic                     accept;
    logic                     push;
    logic                     entry_ok;
    logic [RATIO_W:0]         inv_ratio;
    logic [CLIP_W-1:0]        clip_val;
    logic [ACC_W:0]           rounded;
    logic [LIKE_W-1:0]        merge_res;
    logic [COUNT_BITS-1:0]    cnt_inc;

    mac_ctl_t                 mac_ctl;
    logic [MUL_A_W-1:0]       op_a;
    logic [MUL_B_W-1:0]       op_b;
    logic [ACC_W-1:0]         mac_acc;

    tbl_ctl_t                 tbl_ctl;
    logic [ADDR_W-1:0]        tbl_addr;
    logic [LIKE_W-1:0]        prim_wdata;
    logic [COUNT_BITS-1:0]    cnt_wdata;
    logic [LIKE_W-1:0]        prim_rdata;
    logic [COUNT_BITS-1:0]    cnt_rdata;

    hbp_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .op_a  (op_a),
        .op_b  (op_b),
        .acc   (mac_acc)
    );

    hbp_tables #(
        .DEPTH (TABLE_SIZE),
        .CNT_W (COUNT_BITS)
    ) u_tables (
        .clk        (clk),
        .ctl        (tbl_ctl),
        .addr       (tbl_addr),
        .prim_wdata (prim_wdata),
        .cnt_wdata  (cnt_wdata),
        .prim_rdata (prim_rdata),
        .cnt_rdata  (cnt_rdata)
    );

    assign accept = in_valid && !in_stall;

    assign diff_a = DIFF_W'(chan_a_reg) - DIFF_W'(start_ch1_reg);
    assign diff_b = DIFF_W'(chan_b_reg) - DIFF_W'(start_ch2_reg);
    assign diff_c = DIFF_W'(chan_c_reg) - DIFF_W'(start_ch3_reg);
    assign mag_a  = diff_a[DIFF_W-1] ? $unsigned(-diff_a) : $unsigned(diff_a);
    assign mag_b  = diff_b[DIFF_W-1] ? $unsigned(-diff_b) : $unsigned(diff_b);
    assign mag_c  = diff_c[DIFF_W-1] ? $unsigned(-diff_c) : $unsigned(diff_c);

    // The accumulator holds |v - start| * scale; a negative difference lands in bin 0 while its
    // magnitude stays below one whole bin.
    always_comb
    begin
        case (state_reg)
            S_EVAL_B:
            begin
                eval_neg  = diff_b[DIFF_W-1];
                eval_bins = DIFF_W'(BINS_B);
            end
            S_EVAL_C:
            begin
                eval_neg  = diff_c[DIFF_W-1];
                eval_bins = DIFF_W'(BINS_C);
            end
            default:
            begin
                eval_neg  = diff_a[DIFF_W-1];
                eval_bins = DIFF_W'(BINS_A);
            end
        endcase
        eval_q   = mac_acc[BIN_PROD_W-1:FRAC_W];
        eval_ok  = eval_neg ? (eval_q == '0) : (eval_q < eval_bins);
        eval_bin = eval_neg ? '0 : eval_q;
    end

    assign entry_ok  = 32'(entry_index_reg) < TABLE_SIZE;
    assign inv_ratio = {1'b1, {RATIO_W{1'b0}}} - {1'b0, blend_ratio_reg};
    assign clip_val  = (mac_acc > MERGE_CLIP) ? CLIP_W'(MERGE_CLIP) : mac_acc[CLIP_W-1:0];
    assign rounded   = {1'b0, mac_acc} + ROUND_HALF;
    assign merge_res = (rounded[ACC_W:RES_SHIFT+LIKE_W] != '0) ? '1
                                                                : rounded[RES_SHIFT+LIKE_W-1:RES_SHIFT];
    assign cnt_inc   = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sweep_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd_t'(cmd))
                        CMD_CLASSIFY: state_next = S_BIN_A;
                        CMD_INSERT:   state_next = S_BIN_A;
                        CMD_WRITE:    state_next = S_WRITE;
                        CMD_FLUSH:    state_next = S_FLUSH;
                        CMD_MERGE:    state_next = S_M_READ;
                        default:      state_next = S_DONE;
                    endcase
                end
            end
            S_BIN_A:    state_next = S_BIN_B;
            S_BIN_B:    state_next = S_BIN_C;
            S_BIN_C:    state_next = S_EVAL_B;
            S_EVAL_B:   state_next = S_EVAL_C;
            S_EVAL_C:   state_next = S_LOOKUP;
            S_LOOKUP:   state_next = S_UPDATE;
            S_UPDATE:   state_next = S_DONE;
            S_WRITE:    state_next = S_DONE;
            S_FLUSH:
            begin
                if (sweep_reg == LAST_ADDR)
                begin
                    state_next = S_DONE;
                end
            end
            S_M_READ:   state_next = S_M_MUL_C;
            S_M_MUL_C:  state_next = S_M_WAIT_C;
            S_M_WAIT_C: state_next = S_M_CLIP;
            S_M_CLIP:   state_next = S_M_MUL_LO;
            S_M_MUL_LO: state_next = S_M_MUL_HI;
            S_M_MUL_HI: state_next = S_M_MUL_P;
            S_M_MUL_P:  state_next = S_M_WAIT_S;
            S_M_WAIT_S: state_next = S_M_STORE;
            S_M_STORE:  state_next = (sweep_reg == LAST_ADDR) ? S_DONE : S_M_READ;
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        push       = 1'b0;
        mac_ctl    = '0;
        op_a       = '0;
        op_b       = '0;
        tbl_ctl    = '0;
        tbl_addr   = sweep_reg;
        prim_wdata = merge_res;
        cnt_wdata  = '0;
        sweep_next = sweep_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
            end
            S_CLEAR, S_FLUSH:
            begin
                tbl_ctl.cnt_we = 1'b1;
                sweep_next     = (sweep_reg == LAST_ADDR) ? '0 : sweep_reg + 1'b1;
            end
            S_BIN_A:
            begin
                mac_ctl = '{issue: 1'b1, clear: 1'b1, shift: SH_0};
                op_a    = MUL_A_W'(scale_ch1_reg);
                op_b    = MUL_B_W'(mag_a);
            end
            S_BIN_B:
            begin
                mac_ctl = '{issue: 1'b1, clear: 1'b1, shift: SH_0};
                op_a    = MUL_A_W'(scale_ch2_reg);
                op_b    = MUL_B_W'(mag_b);
            end
            S_BIN_C:
            begin
                mac_ctl = '{issue: 1'b1, clear: 1'b1, shift: SH_0};
                op_a    = MUL_A_W'(scale_ch3_reg);
                op_b    = MUL_B_W'(mag_c);
            end
            S_LOOKUP:
            begin
                tbl_ctl.rd_en = ok_reg;
                tbl_addr      = idx_reg;
            end
            S_UPDATE:
            begin
                tbl_ctl.cnt_we = ok_reg && (cmd_reg == CMD_INSERT);
                tbl_addr       = idx_reg;
                cnt_wdata      = cnt_inc;
            end
            S_WRITE:
            begin
                tbl_ctl.prim_we = entry_ok;
                tbl_addr        = ADDR_W'(entry_index_reg);
                prim_wdata      = entry_value_reg;
            end
            S_M_READ:
            begin
                tbl_ctl.rd_en = 1'b1;
            end
            S_M_MUL_C:
            begin
                mac_ctl = '{issue: 1'b1, clear: 1'b1, shift: SH_0};
                op_a    = MUL_A_W'(cnt_rdata);
                op_b    = count_norm_reg;
            end
            S_M_MUL_LO:
            begin
                mac_ctl = '{issue: 1'b1, clear: 1'b1, shift: SH_0};
                op_a    = a_reg[MUL_A_W-1:0];
                op_b    = MUL_B_W'(blend_ratio_reg);
            end
            S_M_MUL_HI:
            begin
                mac_ctl = '{issue: 1'b1, clear: 1'b0, shift: SH_32};
                op_a    = MUL_A_W'(a_reg[CLIP_W-1:MUL_A_W]);
                op_b    = MUL_B_W'(blend_ratio_reg);
            end
            S_M_MUL_P:
            begin
                mac_ctl = '{issue: 1'b1, clear: 1'b0, shift: SH_8};
                op_a    = MUL_A_W'(inv_ratio);
                op_b    = MUL_B_W'(prim_rdata);
            end
            S_M_STORE:
            begin
                tbl_ctl.prim_we = 1'b1;
                prim_wdata      = merge_res;
                sweep_next      = (sweep_reg == LAST_ADDR) ? '0 : sweep_reg + 1'b1;
            end
            S_DONE:
            begin
                push = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
            start_ch1_reg <= '0;
            start_ch2_reg <= '0;
            start_ch3_reg <= '0;
            scale_ch1_reg <= CHAN_W'(4096);
            scale_ch2_reg <= CHAN_W'(4096);
            scale_ch3_reg <= CHAN_W'(4096);
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_START_CH1: start_ch1_reg <= cfg_data;
                    CFG_START_CH2: start_ch2_reg <= cfg_data;
                    CFG_START_CH3: start_ch3_reg <= cfg_data;
                    CFG_SCALE_CH1: scale_ch1_reg <= cfg_data;
                    CFG_SCALE_CH2: scale_ch2_reg <= cfg_data;
                    CFG_SCALE_CH3: scale_ch3_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg         <= cmd;
            chan_a_reg      <= chan_a;
            chan_b_reg      <= chan_b;
            chan_c_reg      <= chan_c;
            entry_index_reg <= entry_index;
            entry_value_reg <= entry_value;
            blend_ratio_reg <= blend_ratio;
            count_norm_reg  <= count_norm;
            ok_reg          <= 1'b0;
            like_reg        <= '0;
        end
        case (state_reg)
            S_BIN_C:
            begin
                ok_reg  <= eval_ok;
                idx_reg <= ADDR_W'(eval_bin);
            end
            S_EVAL_B:
            begin
                ok_reg  <= ok_reg && eval_ok;
                idx_reg <= ADDR_W'(idx_reg * BINS_B) + ADDR_W'(eval_bin);
            end
            S_EVAL_C:
            begin
                ok_reg  <= ok_reg && eval_ok;
                idx_reg <= ADDR_W'(idx_reg * BINS_C) + ADDR_W'(eval_bin);
            end
            S_UPDATE:
            begin
                if (ok_reg && (cmd_reg == CMD_CLASSIFY))
                begin
                    like_reg <= prim_rdata;
                end
            end
            S_WRITE:
            begin
                ok_reg <= entry_ok;
            end
            S_M_CLIP:
            begin
                a_reg <= clip_val;
            end
            default:
            begin
            end
        endcase
        if (push)
        begin
            likelihood_reg <= like_reg;
            in_range_reg   <= ok_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign likelihood = likelihood_reg;
    assign in_range   = in_range_reg;

    `ASSERT_NEVER(a_single_table_write, tbl_ctl.prim_we && tbl_ctl.cnt_we)
    `ASSERT_IMPL(a_table_addr_range, tbl_ctl.prim_we || tbl_ctl.cnt_we || tbl_ctl.rd_en,
                 32'(tbl_addr) < TABLE_SIZE)
    `ASSERT_NEVER(a_no_result_overwrite, push && out_valid_reg && out_stall)
    `ASSERT_NEXT(a_busy_after_accept, accept, in_stall)
    `ASSERT_IMPL(a_sweep_parked_when_idle, state_reg == S_IDLE, sweep_reg == '0)

endmodule

>>> dv/color_histogram_backprojection_tb.sv
module color_histogram_backprojection_tb;
    import hbp_pkg::*;

    localparam int NBINS = DEF_BINS;
    localparam int GRID = NBINS * NBINS * NBINS;
    localparam int CNT_W = DEF_COUNT_BITS;
    localparam logic [CNT_W-1:0] CNT_TOP = '1;
    localparam logic [CMD_W-1:0] CMD_SPARE = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST = 3'd7;
    localparam longint unsigned MERGE_CAP = 64'd1 << 40;
    localparam int RANDOM_BEATS = 1900;
    localparam int GRID_SETTINGS = 6;
    localparam int IDLE_LIMIT = 4 * (9 * GRID + 200);

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [CHAN_W-1:0]  ch_a;
        logic [CHAN_W-1:0]  ch_b;
        logic [CHAN_W-1:0]  ch_c;
        logic [ENTRY_W-1:0] index;
        logic [LIKE_W-1:0]  value;
        logic [RATIO_W-1:0] ratio;
        logic [NORM_W-1:0]  norm;
    } pixel_beat_t;

    typedef struct packed {
        logic [LIKE_W-1:0] likelihood;
        logic              in_range;
    } lookup_t;

    typedef struct packed {
        pixel_beat_t beat;
        logic        fixed_want;
        lookup_t     want;
    } opening_row_t;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [CMD_W-1:0]          cmd = '0;
    logic signed [CHAN_W-1:0]  chan_a = '0;
    logic signed [CHAN_W-1:0]  chan_b = '0;
    logic signed [CHAN_W-1:0]  chan_c = '0;
    logic [ENTRY_W-1:0]        entry_index = '0;
    logic [LIKE_W-1:0]         entry_value = '0;
    logic [RATIO_W-1:0]        blend_ratio = '0;
    logic [NORM_W-1:0]         count_norm = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [LIKE_W-1:0]         likelihood;
    logic                      in_range;

    color_histogram_backprojection u_top (.*);

    logic [LIKE_W-1:0] like_grid [GRID];
    logic [CNT_W-1:0]  hit_counts [GRID];
    logic [CFG_W-1:0]  grid_start [3];
    logic [CFG_W-1:0]  grid_scale [3];
    lookup_t           due_lookups [$];
    opening_row_t      opening_rows [$];

    int fails = 0;
    int in_calm = 0;
    int out_calm = 0;
    int out_hold = 0;
    int quiet_cycles = 0;
    int n_classify = 0;
    int n_hits = 0;
    int n_insert = 0;
    int n_write = 0;
    int n_flush = 0;
    int n_merge = 0;
    int n_spare = 0;
    int n_settings = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit grid_bin(input logic [CHAN_W-1:0] v, input int ch, output int bin);
        longint p;
        p = (longint'($signed(v)) - longint'($signed(grid_start[ch])))
            * longint'(grid_scale[ch]);
        bin = 0;
        if (p <= -64'sd65536)
            return 1'b0;
        if (p > 0)
            bin = int'(p >>> 16);
        return bin < NBINS;
    endfunction

    function automatic bit grid_index(input pixel_beat_t b, output int idx);
        int b1;
        int b2;
        int b3;
        idx = 0;
        if (!grid_bin(b.ch_a, 0, b1) || !grid_bin(b.ch_b, 1, b2) || !grid_bin(b.ch_c, 2, b3))
            return 1'b0;
        idx = b1 * NBINS * NBINS + b2 * NBINS + b3;
        return 1'b1;
    endfunction

    function automatic lookup_t histogram_step(input pixel_beat_t b);
        lookup_t r;
        int idx;
        longint unsigned prod;
        longint unsigned acc;
        longint unsigned rounded;
        r = '0;
        case (b.cmd)
            CMD_CLASSIFY:
            begin
                n_classify++;
                if (grid_index(b, idx))
                begin
                    r.likelihood = like_grid[idx];
                    r.in_range = 1'b1;
                    n_hits++;
                end
            end
            CMD_INSERT:
            begin
                n_insert++;
                if (grid_index(b, idx))
                begin
                    if (hit_counts[idx] != CNT_TOP)
                        hit_counts[idx] = hit_counts[idx] + 1'b1;
                    r.in_range = 1'b1;
                end
            end
            CMD_WRITE:
            begin
                n_write++;
                if (int'(b.index) < GRID)
                begin
                    like_grid[b.index] = b.value;
                    r.in_range = 1'b1;
                end
            end
            CMD_FLUSH:
            begin
                n_flush++;
                for (int i = 0; i < GRID; i++)
                    hit_counts[i] = '0;
            end
            CMD_MERGE:
            begin
                n_merge++;
                for (int i = 0; i < GRID; i++)
                begin
                    prod = 64'(hit_counts[i]) * 64'(b.norm);
                    if (prod > MERGE_CAP)
                        prod = MERGE_CAP;
                    acc = 64'(b.ratio) * prod
                        + (((64'd65536 - 64'(b.ratio)) * 64'(like_grid[i])) << 8);
                    rounded = (acc + (64'd1 << 23)) >> 24;
                    if (rounded > 64'hFFFF)
                        rounded = 64'hFFFF;
                    like_grid[i] = LIKE_W'(rounded);
                end
            end
            default:
                n_spare++;
        endcase
        return r;
    endfunction

    function automatic logic [CHAN_W-1:0] aim_chan(input int ch);
        int span;
        int lo;
        if ($urandom_range(0, 4) == 0)
            return CHAN_W'($urandom);
        span = (grid_scale[ch] == 0) ? 65536 : (NBINS * 65536) / int'(grid_scale[ch]) + 1;
        if (span > 65536)
            span = 65536;
        lo = -(span / 8) - 2;
        return CHAN_W'(int'($signed(grid_start[ch])) + lo
                       + int'($urandom_range(0, span + span / 4 + 4)));
    endfunction

    function automatic pixel_beat_t random_beat();
        pixel_beat_t b;
        int pick;
        pick = $urandom_range(0, 999);
        if (pick < 450)
            b.cmd = CMD_CLASSIFY;
        else if (pick < 800)
            b.cmd = CMD_INSERT;
        else if (pick < 940)
            b.cmd = CMD_WRITE;
        else if (pick < 955)
            b.cmd = CMD_FLUSH;
        else if (pick < 959)
            b.cmd = CMD_MERGE;
        else
            b.cmd = CMD_SPARE + CMD_W'($urandom_range(0, 2));
        b.ch_a = aim_chan(0);
        b.ch_b = aim_chan(1);
        b.ch_c = aim_chan(2);
        b.index = ENTRY_W'($urandom);
        b.value = LIKE_W'($urandom);
        case ($urandom_range(0, 9))
            0: b.ratio = '0;
            1: b.ratio = '1;
            default: b.ratio = RATIO_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0: b.norm = '0;
            1: b.norm = '1;
            default: b.norm = NORM_W'($urandom);
        endcase
        return b;
    endfunction

    function automatic int beat_gap();
        int pick;
        if (in_calm > 0)
        begin
            in_calm--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 2)
        begin
            in_calm = $urandom_range(50, 150);
            return 0;
        end
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic void add_row(input logic [CMD_W-1:0] c, input logic [CHAN_W-1:0] a,
                                    input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] d,
                                    input logic [ENTRY_W-1:0] idx, input logic [LIKE_W-1:0] v,
                                    input logic [RATIO_W-1:0] r, input logic [NORM_W-1:0] n,
                                    input bit fixed, input logic [LIKE_W-1:0] like,
                                    input logic rng);
        opening_row_t row;
        row.beat = '{cmd: c, ch_a: a, ch_b: b, ch_c: d, index: idx, value: v, ratio: r,
                     norm: n};
        row.fixed_want = fixed;
        row.want = '{likelihood: like, in_range: rng};
        opening_rows.push_back(row);
    endfunction

    task automatic send_beat(input pixel_beat_t b, input bit fixed, input lookup_t want);
        int gap;
        lookup_t got;
        gap = beat_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= b.cmd;
        chan_a <= b.ch_a;
        chan_b <= b.ch_b;
        chan_c <= b.ch_c;
        entry_index <= b.index;
        entry_value <= b.value;
        blend_ratio <= b.ratio;
        count_norm <= b.norm;
        do @(posedge clk); while (in_stall);
        got = histogram_step(b);
        due_lookups.push_back(fixed ? want : got);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (due_lookups.size() != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input cfg_reg_t r, input logic [CFG_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= d;
        @(posedge clk);
        case (r)
            CFG_START_CH1: grid_start[0] = d;
            CFG_START_CH2: grid_start[1] = d;
            CFG_START_CH3: grid_start[2] = d;
            CFG_SCALE_CH1: grid_scale[0] = d;
            CFG_SCALE_CH2: grid_scale[1] = d;
            CFG_SCALE_CH3: grid_scale[2] = d;
            default: ;
        endcase
    endtask

    task automatic program_grid(input logic [2:0][CFG_W-1:0] st,
                                input logic [2:0][CFG_W-1:0] sc);
        reg_write(CFG_START_CH1, st[0]);
        reg_write(CFG_START_CH2, st[1]);
        reg_write(CFG_START_CH3, st[2]);
        reg_write(CFG_SCALE_CH1, sc[0]);
        reg_write(CFG_SCALE_CH2, sc[1]);
        reg_write(CFG_SCALE_CH3, sc[2]);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    always @(posedge clk)
    begin : out_stall_gen
        int pick;
        pick = $urandom_range(0, 99);
        if (out_calm > 0)
        begin
            out_calm--;
            out_stall <= 1'b0;
        end
        else if (out_hold > 0)
        begin
            out_hold--;
            out_stall <= 1'b1;
        end
        else if (pick < 2)
        begin
            out_calm = $urandom_range(60, 300);
            out_stall <= 1'b0;
        end
        else if (pick < 70)
            out_stall <= 1'b0;
        else if (pick < 95)
        begin
            out_hold = $urandom_range(0, 2);
            out_stall <= 1'b1;
        end
        else
        begin
            out_hold = $urandom_range(8, 60);
            out_stall <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        lookup_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_lookups.size() == 0)
            begin
                $error("result beat with nothing expected: likelihood %h in_range %b",
                       likelihood, in_range);
                fails++;
            end
            else
            begin
                want = due_lookups.pop_front();
                if (likelihood !== want.likelihood)
                begin
                    $error("likelihood mismatch: expected %h, got %h", want.likelihood,
                           likelihood);
                    fails++;
                end
                if (in_range !== want.in_range)
                begin
                    $error("in_range mismatch: expected %b, got %b", want.in_range, in_range);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        pixel_beat_t b;
        logic [2:0][CFG_W-1:0] st;
        logic [2:0][CFG_W-1:0] sc;
        for (int i = 0; i < GRID; i++)
            hit_counts[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        program_grid({3{16'd0}}, {3{16'd4096}});

        // Every likelihood entry is loaded first so no later lookup or merge sees an
        // unwritten one.
        for (int i = 0; i < GRID; i++)
        begin
            b = random_beat();
            b.cmd = CMD_WRITE;
            b.index = ENTRY_W'(i);
            send_beat(b, 1'b0, '0);
        end

        add_row(CMD_WRITE, 0, 0, 0, 0, 16'hFFFF, 0, 0, 1, 0, 1);
        add_row(CMD_WRITE, 0, 0, 0, ENTRY_W'(GRID - 1), 16'h8001, 0, 0, 1, 0, 1);
        add_row(CMD_WRITE, 0, 0, 0, 1, 16'h0000, 0, 0, 1, 0, 1);
        add_row(CMD_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 1, 16'hFFFF, 1);
        add_row(CMD_CLASSIFY, 255, 255, 255, 0, 0, 0, 0, 1, 16'h8001, 1);
        add_row(CMD_CLASSIFY, -16'sd1, -16'sd15, 16, 0, 0, 0, 0, 1, 16'h0000, 1);
        add_row(CMD_CLASSIFY, 256, 0, 0, 0, 0, 0, 0, 1, 0, 0);
        add_row(CMD_CLASSIFY, 0, -16'sd16, 0, 0, 0, 0, 0, 1, 0, 0);
        add_row(CMD_CLASSIFY, 0, 0, 16'h8000, 0, 0, 0, 0, 1, 0, 0);
        add_row(CMD_CLASSIFY, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0, 1, 0, 0);
        add_row(CMD_INSERT, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1);
        add_row(CMD_INSERT, -16'sd1, -16'sd1, -16'sd1, 0, 0, 0, 0, 1, 0, 1);
        add_row(CMD_INSERT, 255, 255, 255, 0, 0, 0, 0, 1, 0, 1);
        add_row(CMD_INSERT, 0, 256, 0, 0, 0, 0, 0, 1, 0, 0);
        add_row(CMD_SPARE, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1, '1, '1, '1, 1, 0, 0);
        add_row(CMD_SPARE_LAST, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0);
        add_row(CMD_MERGE, 0, 0, 0, 0, 0, 16'h0000, 24'hFFFFFF, 1, 0, 0);
        add_row(CMD_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 1, 16'hFFFF, 1);
        add_row(CMD_MERGE, 0, 0, 0, 0, 0, 16'hFFFF, 24'hFFFFFF, 1, 0, 0);
        add_row(CMD_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_FLUSH, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0);
        add_row(CMD_INSERT, 10, 20, 30, 0, 0, 0, 0, 1, 0, 1);
        add_row(CMD_MERGE, 0, 0, 0, 0, 0, 16'h8000, 24'h000000, 1, 0, 0);
        add_row(CMD_CLASSIFY, 10, 20, 30, 0, 0, 0, 0, 0, 0, 0);
        foreach (opening_rows[i])
            send_beat(opening_rows[i].beat, opening_rows[i].fixed_want, opening_rows[i].want);

        for (int ph = 0; ph < GRID_SETTINGS; ph++)
        begin
            drain_results();
            for (int ch = 0; ch < 3; ch++)
            begin
                case (ph)
                    0:
                    begin
                        st[ch] = 16'h8000;
                        sc[ch] = CFG_W'(ch + 1);
                    end
                    1:
                    begin
                        st[ch] = (ch == 0) ? 16'h7FFF : (ch == 1) ? 16'h8000 : 16'h0000;
                        sc[ch] = (ch == 0) ? 16'hFFFF : (ch == 1) ? 16'd16 : 16'd4096;
                    end
                    2:
                    begin
                        st[ch] = CFG_W'($urandom);
                        sc[ch] = 16'd0;
                    end
                    5:
                    begin
                        st[ch] = CFG_W'($urandom);
                        sc[ch] = CFG_W'($urandom_range(1, 65535));
                    end
                    default:
                    begin
                        st[ch] = CFG_W'(int'($urandom_range(0, 8000)) - 4000);
                        sc[ch] = CFG_W'($urandom_range(512, 16384));
                    end
                endcase
            end
            program_grid(st, sc);
            for (int n = 0; n < RANDOM_BEATS / GRID_SETTINGS; n++)
                send_beat(random_beat(), 1'b0, '0);
        end

        drain_results();
        repeat (40) @(posedge clk);
        $display("Covered %0d classify (%0d in range), %0d insert, %0d write, %0d flush,",
                 n_classify, n_hits, n_insert, n_write, n_flush);
        $display("%0d merge and %0d unused-code beats over %0d bin-grid settings.",
                 n_merge, n_spare, n_settings);
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
